>>> design/sas_pkg.sv
// Shared types and codes of the song arrangement sequencer.
`default_nettype none
package sas_pkg;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_NEXT    = 3'd2;
  localparam logic [2:0] CMD_PREV    = 3'd3;
  localparam logic [2:0] CMD_SET     = 3'd4;
  localparam logic [2:0] CMD_RESTART = 3'd5;

  localparam logic [4:0] ACT_STOP      = 5'd0;
  localparam logic [4:0] ACT_LOOP_FIRST = 5'd1;
  localparam logic [4:0] ACT_LOOP_LAST = 5'd16;
  localparam logic [4:0] ACT_JUMP_POS  = 5'd17;
  localparam logic [4:0] ACT_JUMP_SONG = 5'd18;
  localparam logic [4:0] ACT_MIXER     = 5'd19;
  localparam logic [4:0] ACT_TEMPO     = 5'd20;
  localparam logic [4:0] ACT_MUTES     = 5'd21;

  localparam logic [2:0] KIND_PATTERN = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_TEMPO   = 3'd2;
  localparam logic [2:0] KIND_MIXER   = 3'd3;
  localparam logic [2:0] KIND_MUTES   = 3'd4;
  localparam logic [2:0] KIND_SONG    = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;
  localparam logic [2:0] KIND_STATUS  = 3'd7;

  localparam int MAX_RESULTS = 64;
  localparam int RES_AW      = 6;
  localparam int PLAIN_ROOM  = 61;

  localparam logic [7:0]  TEMPO_MIN     = 8'd25;
  localparam logic [31:0] PATTERN_RESET = 32'h8080_8080;
  localparam logic [31:0] BANK_RESET    = 32'h0302_0100;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] entry_index;
    logic [4:0] action;
    logic [7:0] act_arg;
    logic [7:0] pattern_one;
    logic [7:0] pattern_two;
    logic [7:0] pattern_three;
    logic [7:0] pattern_four;
    logic [7:0] bank_one;
    logic [7:0] bank_two;
    logic [7:0] bank_three;
    logic [7:0] bank_four;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  group;
    logic [6:0]  pattern_out;
    logic [7:0]  bank_out;
    logic [15:0] value_out;
    logic [7:0]  ramp;
    logic        immediate;
    logic [6:0]  position;
    logic [3:0]  loop_count;
    logic [3:0]  loop_limit;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  group;
    logic [6:0]  pattern_out;
    logic [7:0]  bank_out;
    logic [15:0] value_out;
    logic [7:0]  ramp;
    logic        immediate;
  } res_entry_t;

  typedef enum logic [1:0] {
    GO_FINISH = 2'd0,
    GO_WALK   = 2'd1,
    GO_PREV   = 2'd2
  } go_t;

  typedef enum logic [1:0] {
    EX_END  = 2'd0,
    EX_CONT = 2'd1,
    EX_LOOP = 2'd2
  } ex_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic prev_rd;
    logic prev_chk;
    logic walk_rd;
    logic walk_ex;
    logic loop_g;
    logic lim_stop;
    logic lim_err;
    logic finish;
    logic status;
    logic out_rd;
    logic out_load;
    logic out_wait;
  } dp_cmd_t;

  typedef struct packed {
    go_t  go;
    logic hit_limit;
    logic prev_more;
    ex_t  ex;
    logic g_last;
    logic out_last;
    logic xfer;
  } dp_status_t;

endpackage
`default_nettype wire

>>> design/sas_ctrl.sv
// Controller state machine of the song arrangement sequencer.
`default_nettype none
module sas_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire sas_pkg::dp_status_t status,
  output sas_pkg::dp_cmd_t        cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DECODE   = 14'b00000000000010,
    S_PREV_RD  = 14'b00000000000100,
    S_PREV_CHK = 14'b00000000001000,
    S_WALK_RD  = 14'b00000000010000,
    S_WALK_EX  = 14'b00000000100000,
    S_LOOP_G   = 14'b00000001000000,
    S_LIM_STOP = 14'b00000010000000,
    S_LIM_ERR  = 14'b00000100000000,
    S_FINISH   = 14'b00001000000000,
    S_STATUS   = 14'b00010000000000,
    S_OUT_RD   = 14'b00100000000000,
    S_OUT_LOAD = 14'b01000000000000,
    S_OUT_WAIT = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (item_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (status.go)
          sas_pkg::GO_WALK: state_next = S_WALK_RD;
          sas_pkg::GO_PREV: state_next = S_PREV_RD;
          default:          state_next = S_FINISH;
        endcase
      end
      S_PREV_RD:  state_next = S_PREV_CHK;
      S_PREV_CHK: state_next = status.prev_more ? S_PREV_RD : S_WALK_RD;
      S_WALK_RD:  state_next = status.hit_limit ? S_LIM_STOP : S_WALK_EX;
      S_WALK_EX: begin
        case (status.ex)
          sas_pkg::EX_CONT: state_next = S_WALK_RD;
          sas_pkg::EX_LOOP: state_next = S_LOOP_G;
          default:          state_next = S_FINISH;
        endcase
      end
      S_LOOP_G:   if (status.g_last) state_next = S_FINISH;
      S_LIM_STOP: state_next = S_LIM_ERR;
      S_LIM_ERR:  state_next = S_FINISH;
      S_FINISH:   state_next = S_STATUS;
      S_STATUS:   state_next = S_OUT_RD;
      S_OUT_RD:   state_next = S_OUT_LOAD;
      S_OUT_LOAD: state_next = S_OUT_WAIT;
      S_OUT_WAIT: if (status.xfer) state_next = status.out_last ? S_IDLE : S_OUT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && item_valid;
    cmd.decode   = (state == S_DECODE);
    cmd.prev_rd  = (state == S_PREV_RD);
    cmd.prev_chk = (state == S_PREV_CHK);
    cmd.walk_rd  = (state == S_WALK_RD);
    cmd.walk_ex  = (state == S_WALK_EX);
    cmd.loop_g   = (state == S_LOOP_G);
    cmd.lim_stop = (state == S_LIM_STOP);
    cmd.lim_err  = (state == S_LIM_ERR);
    cmd.finish   = (state == S_FINISH);
    cmd.status   = (state == S_STATUS);
    cmd.out_rd   = (state == S_OUT_RD);
    cmd.out_load = (state == S_OUT_LOAD);
    cmd.out_wait = (state == S_OUT_WAIT);
  end

  assign item_stall = (state != S_IDLE);

endmodule
`default_nettype wire

>>> design/sas_datapath.sv
// Datapath of the song arrangement sequencer: song table, position state, result buffer.
`default_nettype none
module sas_datapath #(
  parameter int TABLE_ENTRIES = 128,
  parameter int SONG_COUNT    = 64,
  parameter int WALK_LIMIT    = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sas_pkg::item_t     item,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire logic               result_stall,
  output logic                    result_valid,
  output sas_pkg::result_t        result,
  input  wire sas_pkg::dp_cmd_t   cmd,
  output sas_pkg::dp_status_t     status
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PW = $clog2(TABLE_ENTRIES + 1);
  localparam int WW = $clog2(WALK_LIMIT + 1);
  localparam int RES_AW_L = sas_pkg::RES_AW;

  logic [AW-1:0] pos_mod  [256];
  logic [7:0]    song_mod [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign pos_mod[i]  = AW'(i % TABLE_ENTRIES);
    assign song_mod[i] = 8'(i % SONG_COUNT);
  end

  sas_pkg::item_t in_q;
  logic [PW-1:0]  pos;
  logic [3:0]     rc;
  logic [3:0]     rl;
  logic           mode;
  logic [WW-1:0]  walked;
  logic           imm;
  logic           reload;
  logic           fail;
  logic [1:0]     g;
  logic [6:0]     cnt;
  logic [RES_AW_L-1:0] rd;

  logic [TABLE_ENTRIES-1:0] tbl_valid;
  logic [4:0]  act_mem  [TABLE_ENTRIES];
  logic [7:0]  val_mem  [TABLE_ENTRIES];
  logic [31:0] pat_mem  [TABLE_ENTRIES];
  logic [31:0] bank_mem [TABLE_ENTRIES];
  logic        rd_vld;
  logic [4:0]  rd_act;
  logic [7:0]  rd_val;
  logic [31:0] rd_pat;
  logic [31:0] rd_bank;

  sas_pkg::res_entry_t res_mem [sas_pkg::MAX_RESULTS];
  sas_pkg::res_entry_t res_rd;

  logic          idx_ok;
  logic [AW-1:0] idx_a;
  logic          tbl_we;
  logic [AW-1:0] rd_addr;
  logic          pos_big;
  logic [WW-1:0] walked_n;
  logic [4:0]    a;
  logic [7:0]    v;
  logic [31:0]   pw;
  logic [31:0]   bw;
  logic [7:0]    p_g;
  logic [7:0]    b_g;
  logic          is_loop;
  logic          is_plain_act;
  logic          emit_en;
  logic          emit_plain;
  logic          emit_ok;
  sas_pkg::res_entry_t emit_e;

  assign idx_ok   = (int'(in_q.entry_index) < TABLE_ENTRIES);
  assign idx_a    = AW'(in_q.entry_index);
  assign tbl_we   = cmd.decode && (in_q.command == sas_pkg::CMD_WRITE) && idx_ok;
  assign pos_big  = (int'(pos) >= TABLE_ENTRIES);
  assign rd_addr  = (cmd.walk_rd && pos_big) ? '0 : AW'(pos);
  assign walked_n = walked + WW'(1);

  assign a  = rd_vld ? rd_act : sas_pkg::ACT_STOP;
  assign v  = rd_vld ? rd_val : 8'd0;
  assign pw = rd_vld ? rd_pat : sas_pkg::PATTERN_RESET;
  assign bw = rd_vld ? rd_bank : sas_pkg::BANK_RESET;
  assign p_g = pw[8*g +: 8];
  assign b_g = bw[8*g +: 8];
  assign is_loop = (a >= sas_pkg::ACT_LOOP_FIRST) && (a <= sas_pkg::ACT_LOOP_LAST);
  assign is_plain_act = (a == sas_pkg::ACT_MIXER) || (a == sas_pkg::ACT_TEMPO) ||
                        (a == sas_pkg::ACT_MUTES);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      act_mem[idx_a]  <= in_q.action;
      val_mem[idx_a]  <= in_q.act_arg;
      pat_mem[idx_a]  <= {in_q.pattern_four, in_q.pattern_three,
                          in_q.pattern_two, in_q.pattern_one};
      bank_mem[idx_a] <= {in_q.bank_four, in_q.bank_three, in_q.bank_two, in_q.bank_one};
    end
    if (cmd.prev_rd || cmd.walk_rd) begin
      rd_vld  <= tbl_valid[rd_addr];
      rd_act  <= act_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
      rd_pat  <= pat_mem[rd_addr];
      rd_bank <= bank_mem[rd_addr];
    end
  end

  always_comb begin
    emit_en    = 1'b0;
    emit_plain = 1'b0;
    emit_e     = '0;
    if (cmd.walk_ex) begin
      if (a == sas_pkg::ACT_STOP) begin
        emit_en     = mode;
        emit_e.kind = sas_pkg::KIND_STOP;
      end else if (a == sas_pkg::ACT_JUMP_SONG) begin
        emit_en          = mode;
        emit_e.kind      = sas_pkg::KIND_SONG;
        emit_e.value_out = 16'(song_mod[v]);
      end else if (a == sas_pkg::ACT_MIXER) begin
        emit_en          = 1'b1;
        emit_plain       = 1'b1;
        emit_e.kind      = sas_pkg::KIND_MIXER;
        emit_e.value_out = 16'(v);
      end else if (a == sas_pkg::ACT_TEMPO) begin
        emit_en          = 1'b1;
        emit_plain       = 1'b1;
        emit_e.kind      = sas_pkg::KIND_TEMPO;
        emit_e.value_out = 16'((v < sas_pkg::TEMPO_MIN) ? sas_pkg::TEMPO_MIN : v);
        emit_e.ramp      = pw[7:0];
      end else if (a == sas_pkg::ACT_MUTES) begin
        emit_en          = 1'b1;
        emit_plain       = 1'b1;
        emit_e.kind      = sas_pkg::KIND_MUTES;
        emit_e.value_out = {pw[27:24], pw[19:16], pw[11:8], pw[3:0]};
      end
    end else if (cmd.loop_g) begin
      emit_en            = ~p_g[7];
      emit_plain         = 1'b1;
      emit_e.kind        = sas_pkg::KIND_PATTERN;
      emit_e.group       = g;
      emit_e.pattern_out = p_g[6:0];
      emit_e.bank_out    = b_g;
      emit_e.immediate   = imm;
    end else if (cmd.lim_stop) begin
      emit_en     = 1'b1;
      emit_e.kind = sas_pkg::KIND_STOP;
    end else if (cmd.lim_err) begin
      emit_en     = 1'b1;
      emit_e.kind = sas_pkg::KIND_ERROR;
    end else if (cmd.status) begin
      emit_en     = 1'b1;
      emit_e.kind = sas_pkg::KIND_STATUS;
    end
  end

  assign emit_ok = emit_en && (emit_plain ? (int'(cnt) < sas_pkg::PLAIN_ROOM)
                                          : (int'(cnt) < sas_pkg::MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      res_mem[cnt[RES_AW_L-1:0]] <= emit_e;
    end
    if (cmd.out_rd) begin
      res_rd <= res_mem[rd];
    end
  end

  always_comb begin
    status           = '0;
    status.go        = sas_pkg::GO_FINISH;
    case (in_q.command)
      sas_pkg::CMD_NEXT: if (!(rc < rl)) status.go = sas_pkg::GO_WALK;
      sas_pkg::CMD_PREV: begin
        if (rc == 4'd0) status.go = (pos != '0) ? sas_pkg::GO_PREV : sas_pkg::GO_WALK;
      end
      sas_pkg::CMD_SET:     status.go = sas_pkg::GO_WALK;
      sas_pkg::CMD_RESTART: if (mode) status.go = sas_pkg::GO_WALK;
      default:              status.go = sas_pkg::GO_FINISH;
    endcase
    status.hit_limit = (int'(walked_n) >= WALK_LIMIT);
    status.prev_more = (pos != '0) && !pos_big && (a >= sas_pkg::ACT_MIXER) &&
                       (a <= sas_pkg::ACT_MUTES);
    if (is_loop) begin
      status.ex = sas_pkg::EX_LOOP;
    end else if ((a == sas_pkg::ACT_JUMP_POS) || is_plain_act) begin
      status.ex = sas_pkg::EX_CONT;
    end else begin
      status.ex = sas_pkg::EX_END;
    end
    status.g_last   = (g == 2'd3);
    status.out_last = ({1'b0, rd} + 7'd1 == cnt);
    status.xfer     = !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      rc           <= '0;
      rl           <= '0;
      mode         <= 1'b0;
      result_valid <= 1'b0;
      tbl_valid    <= '0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      if (cmd.decode) begin
        case (in_q.command)
          sas_pkg::CMD_WRITE: if (idx_ok) tbl_valid[idx_a] <= 1'b1;
          sas_pkg::CMD_CLEAR: if (idx_ok) tbl_valid[idx_a] <= 1'b0;
          sas_pkg::CMD_NEXT: begin
            if (rc < rl) rc <= rc + 4'd1;
            else pos <= pos + PW'(1);
          end
          sas_pkg::CMD_PREV: begin
            if (rc != 4'd0) rc <= rc - 4'd1;
            else if (pos != '0) pos <= pos - PW'(1);
          end
          sas_pkg::CMD_SET: pos <= PW'(pos_mod[{1'b0, in_q.entry_index}]);
          sas_pkg::CMD_RESTART: begin
            pos <= '0;
            rc  <= '0;
            rl  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.prev_chk && status.prev_more) begin
        pos <= pos - PW'(1);
      end
      if (cmd.walk_rd && !status.hit_limit && pos_big) begin
        pos <= '0;
      end
      if (cmd.walk_ex) begin
        if (is_loop) begin
          rc <= '0;
          rl <= 4'(a - sas_pkg::ACT_LOOP_FIRST);
        end else if (a == sas_pkg::ACT_JUMP_POS) begin
          pos <= PW'(pos_mod[v]);
        end else if ((a == sas_pkg::ACT_JUMP_SONG) && mode) begin
          pos <= '0;
        end else if (is_plain_act) begin
          pos <= pos + PW'(1);
        end
      end
      if (cmd.finish) begin
        if ((in_q.command == sas_pkg::CMD_RESTART) && fail) begin
          pos <= '0;
          rc  <= '0;
          rl  <= '0;
        end else if (reload) begin
          rc <= rl;
        end
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (cmd.out_wait && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= item;
    end
    if (cmd.decode) begin
      walked <= '0;
      imm    <= (in_q.command == sas_pkg::CMD_RESTART);
      reload <= (in_q.command == sas_pkg::CMD_PREV) && (rc == 4'd0) && (pos != '0);
      fail   <= 1'b0;
      cnt    <= '0;
      rd     <= '0;
    end
    if (cmd.walk_rd) begin
      walked <= walked_n;
      g      <= 2'd0;
    end
    if (cmd.loop_g) begin
      g <= g + 2'd1;
    end
    if (cmd.lim_err) begin
      fail <= 1'b1;
    end
    if (emit_ok) begin
      cnt <= cnt + 7'd1;
    end
    if (cmd.out_load) begin
      result.kind        <= res_rd.kind;
      result.group       <= res_rd.group;
      result.pattern_out <= res_rd.pattern_out;
      result.bank_out    <= res_rd.bank_out;
      result.value_out   <= res_rd.value_out;
      result.ramp        <= res_rd.ramp;
      result.immediate   <= res_rd.immediate;
      result.position    <= 7'(pos);
      result.loop_count  <= rc;
      result.loop_limit  <= rl;
      result.last        <= status.out_last;
    end
    if (cmd.out_wait && !result_stall) begin
      rd <= rd + RES_AW_L'(1);
    end
  end

endmodule
`default_nettype wire

>>> design/song_arrangement_sequencer_unit.sv
// Top level of the song arrangement sequencer.
// One command is taken at a time and its results are sent out only once the
// whole step is done, since every result carries the position and repeat
// counters left behind by the step. A write, clear or plain repeat step walks
// no entries and gives only its status result. A previous step first skips
// back over mixer, tempo and mute entries, one table read and one check each.
// A walk takes a registered table read and a decode per entry, a step per
// pattern group on a loop entry, and ends in a stop and an error result once
// WALK_LIMIT - 1 entries are walked. Each result is then read from the buffer,
// loaded into the output register and held while stalled. The table needs no
// clearing pass after reset: each entry has a valid bit.
`default_nettype none
module song_arrangement_sequencer_unit #(
  parameter int TABLE_ENTRIES = 128,
  parameter int SONG_COUNT    = 64,
  parameter int WALK_LIMIT    = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire sas_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output sas_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic             cfg_data
);

  sas_pkg::dp_cmd_t    cmd;
  sas_pkg::dp_status_t status;

  sas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  sas_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SONG_COUNT    (SONG_COUNT),
    .WALK_LIMIT    (WALK_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
`default_nettype wire

>>> design/sas_checker.sv
// Port checker of the song arrangement sequencer and its bind.
`default_nettype none
module sas_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire sas_pkg::result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("transfer in not followed by busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input open while results pending");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == sas_pkg::KIND_STATUS) |-> result.last)
    else $error("status result not last");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.last |=> !result_valid)
    else $error("result after last");

endmodule

bind song_arrangement_sequencer_unit sas_checker u_sas_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench of the song arrangement sequencer top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int ENTRIES   = 128;
  localparam int SONGS     = 64;
  localparam int WALK_MAX  = 64;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [4:0] ACT_SPARE_LO = 5'd22;
  localparam logic [4:0] ACT_SPARE_HI = 5'd31;
  localparam logic [4:0] ACT_SPARE_MID = 5'd25;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  sas_pkg::item_t    item;
  logic              result_valid;
  logic              result_stall;
  sas_pkg::result_t  result;
  logic              cfg_we;
  logic              cfg_data;

  song_arrangement_sequencer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  // predictor state
  logic [4:0]  act_tab [ENTRIES];
  logic [7:0]  val_tab [ENTRIES];
  logic [31:0] pat_tab [ENTRIES];
  logic [31:0] bnk_tab [ENTRIES];
  int unsigned cur_pos;
  int unsigned rep_count;
  int unsigned rep_limit;
  logic        mode_song;

  sas_pkg::result_t step_res [$];
  sas_pkg::result_t expected_results [$];

  int errors;
  int items_sent;
  int results_seen;
  int walk_limit_hits;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for the block");
    $display("Mismatches found");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic void add_result(input bit plain, input logic [2:0] kind,
                                     input logic [1:0] grp, input logic [6:0] pat,
                                     input logic [7:0] bank, input logic [15:0] val,
                                     input logic [7:0] rmp, input logic imm);
    sas_pkg::result_t r;
    if (plain && step_res.size() >= sas_pkg::PLAIN_ROOM) return;
    if (step_res.size() >= sas_pkg::MAX_RESULTS) return;
    r = '0;
    r.kind = kind;
    r.group = grp;
    r.pattern_out = pat;
    r.bank_out = bank;
    r.value_out = val;
    r.ramp = rmp;
    r.immediate = imm;
    step_res.push_back(r);
  endfunction

  function automatic void add_marker(input logic [2:0] kind);
    add_result(1'b0, kind, '0, '0, '0, '0, '0, 1'b0);
  endfunction

  function automatic void clear_row(input int i);
    act_tab[i] = sas_pkg::ACT_STOP;
    val_tab[i] = '0;
    pat_tab[i] = sas_pkg::PATTERN_RESET;
    bnk_tab[i] = sas_pkg::BANK_RESET;
  endfunction

  function automatic bit walk_song(input logic imm);
    int unsigned walked;
    logic [4:0] a;
    logic [7:0] v;
    logic [31:0] pw;
    logic [31:0] bw;
    walked = 0;
    forever begin
      walked++;
      if (walked >= WALK_MAX) begin
        add_marker(sas_pkg::KIND_STOP);
        add_marker(sas_pkg::KIND_ERROR);
        walk_limit_hits++;
        return 1'b0;
      end
      if (cur_pos >= ENTRIES) cur_pos = 0;
      a = act_tab[cur_pos];
      v = val_tab[cur_pos];
      pw = pat_tab[cur_pos];
      bw = bnk_tab[cur_pos];
      if (a == sas_pkg::ACT_STOP) begin
        if (mode_song) add_marker(sas_pkg::KIND_STOP);
        return 1'b1;
      end else if (a >= sas_pkg::ACT_LOOP_FIRST && a <= sas_pkg::ACT_LOOP_LAST) begin
        rep_count = 0;
        rep_limit = int'(a) - 1;
        for (int g = 0; g < 4; g++) begin
          if (pw[8*g +: 8] < 8'h80)
            add_result(1'b1, sas_pkg::KIND_PATTERN, 2'(g), pw[8*g +: 7], bw[8*g +: 8],
                       '0, '0, imm);
        end
        return 1'b1;
      end else if (a == sas_pkg::ACT_JUMP_POS) begin
        cur_pos = v % ENTRIES;
      end else if (a == sas_pkg::ACT_JUMP_SONG) begin
        if (mode_song) begin
          add_result(1'b0, sas_pkg::KIND_SONG, '0, '0, '0, 16'(v % SONGS), '0, 1'b0);
          cur_pos = 0;
        end
        return 1'b1;
      end else if (a == sas_pkg::ACT_MIXER) begin
        add_result(1'b1, sas_pkg::KIND_MIXER, '0, '0, '0, 16'(v), '0, 1'b0);
        cur_pos++;
      end else if (a == sas_pkg::ACT_TEMPO) begin
        add_result(1'b1, sas_pkg::KIND_TEMPO, '0, '0, '0,
                   16'((v < sas_pkg::TEMPO_MIN) ? sas_pkg::TEMPO_MIN : v), pw[7:0], 1'b0);
        cur_pos++;
      end else if (a == sas_pkg::ACT_MUTES) begin
        add_result(1'b1, sas_pkg::KIND_MUTES, '0, '0, '0,
                   {pw[27:24], pw[19:16], pw[11:8], pw[3:0]}, '0, 1'b0);
        cur_pos++;
      end else begin
        return 1'b1;
      end
    end
  endfunction

  function automatic void predict_step(input sas_pkg::item_t it);
    bit ok;
    bit reload;
    step_res.delete();
    case (it.command)
      sas_pkg::CMD_WRITE: begin
        act_tab[it.entry_index] = it.action;
        val_tab[it.entry_index] = it.act_arg;
        pat_tab[it.entry_index] = {it.pattern_four, it.pattern_three,
                                   it.pattern_two, it.pattern_one};
        bnk_tab[it.entry_index] = {it.bank_four, it.bank_three, it.bank_two, it.bank_one};
      end
      sas_pkg::CMD_CLEAR: clear_row(int'(it.entry_index));
      sas_pkg::CMD_NEXT: begin
        if (rep_count < rep_limit) rep_count++;
        else begin
          cur_pos++;
          ok = walk_song(1'b0);
        end
      end
      sas_pkg::CMD_PREV: begin
        if (rep_count != 0) rep_count--;
        else begin
          reload = 1'b1;
          if (cur_pos != 0) begin
            cur_pos--;
            while (cur_pos != 0 && cur_pos < ENTRIES &&
                   act_tab[cur_pos] >= sas_pkg::ACT_MIXER &&
                   act_tab[cur_pos] <= sas_pkg::ACT_MUTES)
              cur_pos--;
          end else reload = 1'b0;
          ok = walk_song(1'b0);
          if (reload) rep_count = rep_limit;
        end
      end
      sas_pkg::CMD_SET: begin
        cur_pos = it.entry_index % ENTRIES;
        ok = walk_song(1'b0);
      end
      sas_pkg::CMD_RESTART: begin
        cur_pos = 0;
        rep_count = 0;
        rep_limit = 0;
        if (mode_song && !walk_song(1'b1)) begin
          cur_pos = 0;
          rep_count = 0;
          rep_limit = 0;
        end
      end
      default: ;
    endcase
    add_marker(sas_pkg::KIND_STATUS);
    foreach (step_res[k]) begin
      step_res[k].position = cur_pos[6:0];
      step_res[k].loop_count = rep_count[3:0];
      step_res[k].loop_limit = rep_limit[3:0];
      step_res[k].last = (k == step_res.size() - 1);
      expected_results.push_back(step_res[k]);
    end
  endfunction

  task automatic send_item(input sas_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    predict_step(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_song_mode(input logic m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_song = m;
  endtask

  function automatic sas_pkg::item_t make_item(input logic [2:0] cmd, input logic [6:0] idx,
                                               input logic [4:0] act, input logic [7:0] val,
                                               input logic [31:0] pats,
                                               input logic [31:0] banks);
    sas_pkg::item_t it;
    it.command = cmd;
    it.entry_index = idx;
    it.action = act;
    it.act_arg = val;
    {it.pattern_four, it.pattern_three, it.pattern_two, it.pattern_one} = pats;
    {it.bank_four, it.bank_three, it.bank_two, it.bank_one} = banks;
    return it;
  endfunction

  function automatic sas_pkg::item_t random_item();
    sas_pkg::item_t it;
    logic [95:0] raw;
    int w;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(sas_pkg::item_t)-1:0];
    w = $urandom_range(99);
    if (w < 32) it.command = sas_pkg::CMD_WRITE;
    else if (w < 37) it.command = sas_pkg::CMD_CLEAR;
    else if (w < 62) it.command = sas_pkg::CMD_NEXT;
    else if (w < 74) it.command = sas_pkg::CMD_PREV;
    else if (w < 84) it.command = sas_pkg::CMD_SET;
    else if (w < 95) it.command = sas_pkg::CMD_RESTART;
    else it.command = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    if ($urandom_range(9) < 8) it.entry_index = 7'($urandom_range(15));
    w = $urandom_range(99);
    if (w < 10) it.action = sas_pkg::ACT_STOP;
    else if (w < 45)
      it.action = 5'($urandom_range(sas_pkg::ACT_LOOP_FIRST, sas_pkg::ACT_LOOP_LAST));
    else if (w < 55) it.action = sas_pkg::ACT_JUMP_POS;
    else if (w < 61) it.action = sas_pkg::ACT_JUMP_SONG;
    else if (w < 71) it.action = sas_pkg::ACT_MIXER;
    else if (w < 79) it.action = sas_pkg::ACT_TEMPO;
    else if (w < 88) it.action = sas_pkg::ACT_MUTES;
    else it.action = 5'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if (it.action == sas_pkg::ACT_JUMP_POS && $urandom_range(1))
      it.act_arg = 8'($urandom_range(15));
    return it;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_directed();
    send_item(make_item(sas_pkg::CMD_RESTART, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_NEXT, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_PREV, '0, '0, '0, '0, '0));
    send_item(make_item(CMD_SPARE_LO, 7'h7f, 5'h1f, 8'hff, '1, '1));
    send_item(make_item(CMD_SPARE_HI, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd1, sas_pkg::ACT_LOOP_FIRST + 5'd3, '0,
                        32'h81_7f_00_05, 32'hff_00_aa_55));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd2, sas_pkg::ACT_TEMPO, 8'd10,
                        32'h00_00_00_ff, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd3, sas_pkg::ACT_TEMPO, 8'hff, '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd4, sas_pkg::ACT_MIXER, 8'hff, '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd5, sas_pkg::ACT_MUTES, '0,
                        32'hf5_a3_3c_ff, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd6, sas_pkg::ACT_LOOP_LAST, '0,
                        32'h00_7f_80_ff, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd7, sas_pkg::ACT_JUMP_SONG, 8'd200, '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd8, ACT_SPARE_MID, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd127, sas_pkg::ACT_JUMP_POS, 8'd129, '0, '0));
    send_item(make_item(sas_pkg::CMD_SET, 7'd1, '0, '0, '0, '0));
    repeat (4) send_item(make_item(sas_pkg::CMD_NEXT, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_PREV, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_PREV, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_NEXT, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_SET, 7'd127, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_CLEAR, 7'd127, '0, '0, '0, '0));
    set_song_mode(1'b1);
    send_item(make_item(sas_pkg::CMD_SET, 7'd6, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_NEXT, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_RESTART, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_SET, 7'd9, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_SET, 7'd8, '0, '0, '0, '0));
  endtask

  task automatic test_walk_limit();
    for (int i = 0; i < 40; i++)
      send_item(make_item(sas_pkg::CMD_WRITE, 7'(i), sas_pkg::ACT_MIXER, 8'(i), '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, 7'd40, sas_pkg::ACT_JUMP_POS, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_RESTART, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_SET, 7'd20, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_WRITE, '0, sas_pkg::ACT_JUMP_POS, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_NEXT, '0, '0, '0, '0, '0));
    set_song_mode(1'b0);
    send_item(make_item(sas_pkg::CMD_RESTART, '0, '0, '0, '0, '0));
    send_item(make_item(sas_pkg::CMD_SET, '0, '0, '0, '0, '0));
    for (int i = 0; i <= 40; i++)
      send_item(make_item(sas_pkg::CMD_CLEAR, 7'(i), '0, '0, '0, '0));
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(80);
    set_song_mode(1'b1);
    send_idle_pct = 65; recv_stall_pct = 0;  run_random(80);
    send_idle_pct = 0;  recv_stall_pct = 65; run_random(80);
    set_song_mode(1'b0);
    send_idle_pct = 17; recv_stall_pct = 17; run_random(80);
    set_song_mode(1'b1);
    send_idle_pct = 0;  recv_stall_pct = 17; run_random(40);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 400;
    run_random(30);
    set_song_mode(1'b0);
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sas_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected result", result, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.kind !== want.kind) report("kind", result.kind, want.kind);
        if (result.group !== want.group) report("group", result.group, want.group);
        if (result.pattern_out !== want.pattern_out)
          report("pattern_out", result.pattern_out, want.pattern_out);
        if (result.bank_out !== want.bank_out) report("bank_out", result.bank_out, want.bank_out);
        if (result.value_out !== want.value_out)
          report("value_out", result.value_out, want.value_out);
        if (result.ramp !== want.ramp) report("ramp", result.ramp, want.ramp);
        if (result.immediate !== want.immediate)
          report("immediate", result.immediate, want.immediate);
        if (result.position !== want.position) report("position", result.position, want.position);
        if (result.loop_count !== want.loop_count)
          report("loop_count", result.loop_count, want.loop_count);
        if (result.loop_limit !== want.loop_limit)
          report("loop_limit", result.loop_limit, want.loop_limit);
        if (result.last !== want.last) report("last", result.last, want.last);
      end
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    walk_limit_hits = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    for (int i = 0; i < ENTRIES; i++) clear_row(i);
    cur_pos = 0;
    rep_count = 0;
    rep_limit = 0;
    mode_song = 1'b0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    result_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_walk_limit();
    test_idle_phases();
    test_backpressure();
    wait_drained();

    $display("Sent %0d commands, checked %0d results, %0d walks hit the entry limit",
             items_sent, results_seen, walk_limit_hits);
    $display("Covered both song modes, sender gaps, receiver stalls and a long hold-off");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
